### rtl/chained_hash_table_assert.svh
// Assertion macros for the chained hash table RTL.
// Included by the modules that carry concurrent checks; no dependencies.
`ifndef CHAINED_HASH_TABLE_ASSERT_SVH
`define CHAINED_HASH_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

`define CHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define CHT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define CHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define CHT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### rtl/cht_pkg.sv
// Shared types and constants of the chained hash table.
// No dependencies; imported by every module of the block but cht_ram.
package cht_pkg;

	localparam int KEY_W      = 31;
	localparam int STATUS_W   = 2;
	localparam int BUCKET_W   = 4;
	localparam int POS_W      = 4;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_FIND   = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 2'd0,
		ST_FOUND     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		op_t              op;
		logic [KEY_W-1:0] key;
	} item_t;

endpackage

### rtl/cht_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cht_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 80,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/cht_front.sv
// Front end: takes items, reduces the key modulo the bucket count by a
// reciprocal multiply and a subtract. Depends on cht_pkg; feeds cht_queue.
module cht_front import cht_pkg::*; #(
	parameter int BUCKETS = 10,
	localparam int BW = $clog2(BUCKETS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic             op,
	input  logic [KEY_W-1:0] key,
	input  logic             q_full,
	output logic             push,
	output item_t            push_item,
	output logic [BW-1:0]    push_bucket
);

	localparam int              SH    = KEY_W + BW;
	localparam int              MW    = KEY_W + 1;
	localparam int              PRW   = KEY_W + MW;
	localparam longint unsigned SCALE = 64'd1 << SH;
	localparam logic [MW-1:0]   RECIP = MW'((SCALE + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_REM,
		F_PUSH
	} fstate_t;

	fstate_t          state_q;
	item_t            item_q;
	logic [KEY_W-1:0] quo_q;
	logic [BW-1:0]    rem_q;
	logic [PRW-1:0]   prod;
	logic [KEY_W-1:0] quo_nx;
	logic [BW-1:0]    rem_nx;

	assign prod   = PRW'(item_q.key) * PRW'(RECIP);
	assign quo_nx = KEY_W'(prod >> SH);
	assign rem_nx = BW'(item_q.key - quo_q * KEY_W'(BUCKETS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			item_q  <= '0;
			quo_q   <= '0;
			rem_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (start) begin
						item_q  <= '{op: op_t'(op), key: key};
						state_q <= F_DIV;
					end
				end
				F_DIV: begin
					quo_q   <= quo_nx;
					state_q <= F_REM;
				end
				F_REM: begin
					rem_q   <= rem_nx;
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != F_IDLE);
	assign push        = (state_q == F_PUSH) && !q_full;
	assign push_item   = item_q;
	assign push_bucket = rem_q;

endmodule

### rtl/cht_queue.sv
// Short first-in first-out queue between the front and back ends.
// Imports cht_pkg but uses nothing from it; includes the assertion macros.
`include "chained_hash_table_assert.svh"
module cht_queue import cht_pkg::*; #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 2,
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	logic [WIDTH-1:0] ent_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [CW-1:0]    cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = ent_q[rptr_q];

	`CHT_ASSERT_IMP(a_no_overflow, clk, arst_n, push, !full)
	`CHT_ASSERT_IMP(a_no_underflow, clk, arst_n, pop, !empty)
	`CHT_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CW'(DEPTH))

endmodule

### rtl/cht_back.sv
// Back end: keeps chain counts, inserts keys and walks a bucket's chain.
// Depends on cht_pkg and cht_ram.
`include "chained_hash_table_assert.svh"
module cht_back import cht_pkg::*; #(
	parameter int BUCKETS = 10,
	parameter int CHAIN_DEPTH = 8,
	localparam int BW = $clog2(BUCKETS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	output logic                pop,
	input  item_t               q_item,
	input  logic [BW-1:0]       q_bucket,
	output logic                done,
	output logic [STATUS_W-1:0] status,
	output logic [BUCKET_W-1:0] bucket,
	output logic [POS_W-1:0]    position
);

	localparam int ENTRIES = BUCKETS * CHAIN_DEPTH;
	localparam int AW      = $clog2(ENTRIES);
	localparam int CW      = $clog2(CHAIN_DEPTH + 1);

	typedef enum logic {
		B_IDLE,
		B_WALK
	} bstate_t;

	bstate_t            state_q;
	logic [CW-1:0]      counts_q [BUCKETS];
	logic [KEY_W-1:0]   key_q;
	logic [BW-1:0]      bkt_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      iss_q;
	logic [CW-1:0]      cmp_q;
	logic               pend_q;
	logic               done_q;
	status_t            status_q;
	logic [BUCKET_W-1:0] bucket_q;
	logic [POS_W-1:0]   position_q;

	logic [CW-1:0]      cnt_sel;
	logic               is_insert;
	logic               ram_we;
	logic [AW-1:0]      waddr;
	logic               ram_re;
	logic [AW-1:0]      raddr;
	logic [KEY_W-1:0]   rdata;
	logic               hit;

	assign pop       = (state_q == B_IDLE) && !q_empty;
	assign cnt_sel   = counts_q[q_bucket];
	assign is_insert = (q_item.op == OP_INSERT);
	assign ram_we    = pop && is_insert && (cnt_sel < CW'(CHAIN_DEPTH));
	assign waddr     = AW'(q_bucket) * AW'(CHAIN_DEPTH) + AW'(cnt_sel);
	assign hit       = pend_q && (rdata == key_q);
	assign ram_re    = (state_q == B_WALK) && (iss_q < cnt_q) && !hit;
	assign raddr     = AW'(bkt_q) * AW'(CHAIN_DEPTH) + AW'(cnt_q - CW'(1) - iss_q);

	cht_ram #(
		.WIDTH (KEY_W),
		.DEPTH (ENTRIES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (q_item.key),
		.re    (ram_re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			for (int i = 0; i < BUCKETS; i++) begin
				counts_q[i] <= '0;
			end
			key_q      <= '0;
			bkt_q      <= '0;
			cnt_q      <= '0;
			iss_q      <= '0;
			cmp_q      <= '0;
			pend_q     <= 1'b0;
			done_q     <= 1'b0;
			status_q   <= ST_INSERTED;
			bucket_q   <= '0;
			position_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (pop) begin
						key_q      <= q_item.key;
						bkt_q      <= q_bucket;
						bucket_q   <= BUCKET_W'(q_bucket);
						position_q <= '0;
						if (is_insert) begin
							done_q <= 1'b1;
							if (ram_we) begin
								counts_q[q_bucket] <= cnt_sel + CW'(1);
								status_q <= ST_INSERTED;
							end else begin
								status_q <= ST_FULL;
							end
						end else if (cnt_sel == '0) begin
							done_q   <= 1'b1;
							status_q <= ST_NOT_FOUND;
						end else begin
							cnt_q   <= cnt_sel;
							iss_q   <= '0;
							cmp_q   <= '0;
							pend_q  <= 1'b0;
							state_q <= B_WALK;
						end
					end
				end
				B_WALK: begin
					pend_q <= ram_re;
					if (ram_re) begin
						iss_q <= iss_q + CW'(1);
					end
					if (hit) begin
						done_q     <= 1'b1;
						status_q   <= ST_FOUND;
						position_q <= POS_W'(cmp_q + CW'(1));
						state_q    <= B_IDLE;
					end else if (pend_q) begin
						cmp_q <= cmp_q + CW'(1);
						if (cmp_q + CW'(1) == cnt_q) begin
							done_q   <= 1'b1;
							status_q <= ST_NOT_FOUND;
							state_q  <= B_IDLE;
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	assign done     = done_q;
	assign status   = status_q;
	assign bucket   = bucket_q;
	assign position = position_q;

	`CHT_ASSERT_IMP(a_walk_bounds, clk, arst_n, state_q == B_WALK, (iss_q <= cnt_q) && (cmp_q < cnt_q))
	`CHT_ASSERT_IMP(a_no_full_write, clk, arst_n, ram_we, cnt_sel < CW'(CHAIN_DEPTH))
	`CHT_ASSERT_IMP(a_found_pos, clk, arst_n, done_q && (status_q == ST_FOUND), position_q != '0)
	`CHT_ASSERT_NXT(a_insert_done, clk, arst_n, pop && is_insert, done_q && (state_q == B_IDLE))

endmodule

### rtl/chained_hash_table.sv
// Top level of the chained hash table: front end, queue and back end.
// Depends on cht_pkg, cht_front, cht_queue, cht_back and cht_ram.
//
// Usage: drive op (0 insert, 1 find) and key with start high; the item is
// taken at a rising edge where start is high and busy is low. Every item
// gives exactly one result, shown for one cycle with done high on status,
// bucket and position. The receiver cannot hold results off.
// Flow: the front end finds key modulo BUCKETS by a reciprocal multiply
// and a subtract, registering the quotient and then the remainder, then
// hands the item to a two-entry queue (busy stays high until the item is
// pushed, so also while the queue is full). The back end pops it; an insert
// or a find of an empty bucket is answered without a walk, and a find reads
// the bucket's store one entry a cycle from newest to oldest through the
// RAM's single read port, stopping at a hit. Front and back run
// concurrently, but the front end takes no new item until its last one is
// in the queue, and long finds, by filling the queue, hold it off too.
// Reset clears all chain counts and the queue; the key store needs no
// clearing pass.
module chained_hash_table import cht_pkg::*; #(
	parameter int BUCKETS = 10,
	parameter int CHAIN_DEPTH = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                op,
	input  logic [KEY_W-1:0]    key,
	output logic                done,
	output logic [STATUS_W-1:0] status,
	output logic [BUCKET_W-1:0] bucket,
	output logic [POS_W-1:0]    position
);

	localparam int BW = $clog2(BUCKETS);
	localparam int IW = $bits(item_t);
	localparam int QW = IW + BW;

	logic           push;
	item_t          f_item;
	logic [BW-1:0]  f_bucket;
	logic           q_full;
	logic           q_empty;
	logic           pop;
	logic [QW-1:0]  q_rdata;
	item_t          q_item;
	logic [BW-1:0]  q_bucket;

	cht_front #(
		.BUCKETS (BUCKETS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.key         (key),
		.q_full      (q_full),
		.push        (push),
		.push_item   (f_item),
		.push_bucket (f_bucket)
	);

	cht_queue #(
		.WIDTH (QW),
		.DEPTH (2)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({f_bucket, f_item}),
		.full   (q_full),
		.pop    (pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	assign q_item   = item_t'(q_rdata[IW-1:0]);
	assign q_bucket = q_rdata[QW-1 -: BW];

	cht_back #(
		.BUCKETS     (BUCKETS),
		.CHAIN_DEPTH (CHAIN_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.pop      (pop),
		.q_item   (q_item),
		.q_bucket (q_bucket),
		.done     (done),
		.status   (status),
		.bucket   (bucket),
		.position (position)
	);

endmodule

### sim/chained_hash_table_tb.sv
// Self-checking testbench for chained_hash_table: directed and random inserts and finds,
// checked against a predictor of bucket chains held in the bench.
// Depends on cht_pkg and the chained_hash_table RTL.
module chained_hash_table_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cht_pkg::*;

	localparam int BUCKETS     = 10;
	localparam int CHAIN_DEPTH = 8;
	localparam int STALL_LIMIT = 1000;
	localparam logic [KEY_W-1:0] KEY_MAX = '1;

	typedef struct packed {
		status_t             st;
		logic [BUCKET_W-1:0] bkt;
		logic [POS_W-1:0]    pos;
	} lookup_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                op = 1'b0;
	logic [KEY_W-1:0]    key = '0;
	logic                busy;
	logic                done;
	logic [STATUS_W-1:0] status;
	logic [BUCKET_W-1:0] bucket;
	logic [POS_W-1:0]    position;

	logic [KEY_W-1:0] chain_keys [BUCKETS][CHAIN_DEPTH];
	int unsigned      chain_len [BUCKETS];
	lookup_t          pending_lookups[$];
	logic [KEY_W-1:0] inserted_keys[$];
	int unsigned      errors = 0;
	int unsigned      stall_cycles = 0;
	bit               no_idle = 1'b0;

	chained_hash_table #(
		.BUCKETS(BUCKETS),
		.CHAIN_DEPTH(CHAIN_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.key(key),
		.done(done),
		.status(status),
		.bucket(bucket),
		.position(position)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// insert at the chain head, or walk it from newest to oldest
	function automatic lookup_t predict_lookup(op_t o, logic [KEY_W-1:0] k);
		lookup_t r;
		int unsigned b;
		int unsigned n;
		b = k % BUCKETS;
		n = chain_len[b];
		r.bkt = b[BUCKET_W-1:0];
		r.pos = '0;
		if (o == OP_INSERT) begin
			if (n >= CHAIN_DEPTH) begin
				r.st = ST_FULL;
			end else begin
				chain_keys[b][n] = k;
				chain_len[b] = n + 1;
				r.st = ST_INSERTED;
			end
		end else begin
			r.st = ST_NOT_FOUND;
			for (int w = 0; w < n; w++) begin
				if (chain_keys[b][n - 1 - w] == k) begin
					r.st = ST_FOUND;
					r.pos = POS_W'(w + 1);
					break;
				end
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, int unsigned want, int unsigned got);
		$display("MISMATCH at %0t: %s expected %0d got %0d", $realtime, what, want, got);
		errors++;
	endtask

	task automatic send_item(op_t o, logic [KEY_W-1:0] k);
		int unsigned gap;
		gap = no_idle ? 0 : $urandom_range(16);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		op <= o;
		key <= k;
		do @(posedge clk); while (busy);
		pending_lookups.push_back(predict_lookup(o, k));
		if (o == OP_INSERT)
			inserted_keys.push_back(k);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (pending_lookups.size() != 0) @(posedge clk);
	endtask

	task automatic test_empty_finds();
		send_item(OP_FIND, '0);
		send_item(OP_FIND, KEY_MAX);
	endtask

	task automatic test_chain_order();
		send_item(OP_INSERT, 31'd0);
		send_item(OP_FIND, 31'd0);
		send_item(OP_INSERT, 31'd10);
		send_item(OP_INSERT, 31'd20);
		send_item(OP_FIND, 31'd0);
		send_item(OP_FIND, 31'd10);
		send_item(OP_INSERT, 31'd20);
		send_item(OP_FIND, 31'd20);
		send_item(OP_FIND, 31'd30);
	endtask

	task automatic test_full_bucket();
		send_item(OP_INSERT, 31'd30);
		send_item(OP_INSERT, 31'd40);
		send_item(OP_INSERT, 31'd50);
		send_item(OP_INSERT, 31'd60);
		send_item(OP_INSERT, 31'd70);
		send_item(OP_FIND, 31'd70);
		send_item(OP_FIND, 31'd0);
		send_item(OP_FIND, 31'd60);
	endtask

	task automatic test_wide_keys();
		send_item(OP_INSERT, KEY_MAX);
		send_item(OP_FIND, KEY_MAX);
		send_item(OP_FIND, KEY_MAX - 31'd10);
		send_item(OP_INSERT, 31'h2AAAAAAA);
		send_item(OP_FIND, 31'h55555555);
	endtask

	task automatic test_sender_pause();
		send_item(OP_FIND, 31'd20);
		wait_drained();
		send_item(OP_FIND, 31'h2AAAAAAA);
	endtask

	task automatic test_random(int unsigned count);
		op_t              o;
		logic [KEY_W-1:0] k;
		int unsigned      pick;
		for (int i = 0; i < count; i++) begin
			if (i % 50 == 0)
				no_idle = ($urandom_range(3) == 0);
			if (i == count / 2)
				wait_drained();
			o = ($urandom_range(1) == 0) ? OP_INSERT : OP_FIND;
			pick = $urandom_range(9);
			if (o == OP_FIND && pick < 6 && inserted_keys.size() != 0)
				k = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
			else if (pick < 8)
				k = KEY_W'($urandom_range(99));
			else
				k = KEY_W'($urandom);
			send_item(o, k);
		end
		no_idle = 1'b0;
	endtask

	always @(posedge clk) begin
		lookup_t want;
		if (arst_n && done) begin
			if (pending_lookups.size() == 0) begin
				report_mismatch("unexpected result, status", 0, status);
			end else begin
				want = pending_lookups.pop_front();
				if (want.st != status)
					report_mismatch("status", want.st, status);
				if (want.bkt != bucket)
					report_mismatch("bucket", want.bkt, bucket);
				if (want.pos != position)
					report_mismatch("position", want.pos, position);
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("chained_hash_table test failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		foreach (chain_len[b])
			chain_len[b] = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_finds();
		test_chain_order();
		test_full_bucket();
		test_wide_keys();
		test_sender_pause();
		test_random(775);
		wait_drained();
		repeat (CHAIN_DEPTH + 16) @(posedge clk);
		if (errors == 0)
			$display("chained_hash_table test passed");
		else
			$display("chained_hash_table test failed");
		$finish;
	end

endmodule
